### sv/mwi_message_summary_parser_unit_defines.svh
// assertion macros for the message summary parser
`ifndef MWI_MESSAGE_SUMMARY_PARSER_UNIT_DEFINES_SVH
`define MWI_MESSAGE_SUMMARY_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define MWI_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define MWI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mwi_msp_pkg.sv
// types, constants and character helpers of the message summary parser
`timescale 1ns / 1ps

package mwi_msp_pkg;

  // default count width and output field width
  localparam int COUNT_BITS_DEF = 16;
  localparam int OUT_CNT_W      = 16;
  localparam int IN_DATA_W      = 8;
  localparam int OUT_DATA_W     = 72;
  localparam int POS_W          = 5;

  // keyword lengths
  localparam int MW_LEN  = 17;
  localparam int VM_LEN  = 14;
  localparam int YES_LEN = 3;
  localparam int RADIX   = 10;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_VT     = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;
  localparam logic [7:0] CH_LO_M   = 8'h6d;
  localparam logic [7:0] CH_LO_V   = 8'h76;

  // count register slots
  localparam logic [1:0] CNT_NEW_VOICE  = 2'd0;
  localparam logic [1:0] CNT_OLD_VOICE  = 2'd1;
  localparam logic [1:0] CNT_NEW_URGENT = 2'd2;
  localparam logic [1:0] CNT_OLD_URGENT = 2'd3;

  // line parsing phase
  typedef enum logic [12:0] {
    PH_LINE   = 13'b0000000000001,
    PH_KMW    = 13'b0000000000010,
    PH_KVM    = 13'b0000000000100,
    PH_MWSP   = 13'b0000000001000,
    PH_YES    = 13'b0000000010000,
    PH_SKIP   = 13'b0000000100000,
    PH_VMSP   = 13'b0000001000000,
    PH_NSTART = 13'b0000010000000,
    PH_NWS1   = 13'b0000100000000,
    PH_NWS    = 13'b0001000000000,
    PH_NDIG   = 13'b0010000000000,
    PH_PAREN  = 13'b0100000000000,
    PH_DONE   = 13'b1000000000000
  } phase_t;

  // ascii lower case
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) ? (c + 8'd32) : c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // space, tab, vt, ff, cr; line feed is not a blank here
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

  // "messages-waiting:" by position
  function automatic logic [7:0] kw_waiting(input logic [POS_W-1:0] p);
    logic [7:0] ch;
    case (p)
      5'd0:    ch = "m";
      5'd1:    ch = "e";
      5'd2:    ch = "s";
      5'd3:    ch = "s";
      5'd4:    ch = "a";
      5'd5:    ch = "g";
      5'd6:    ch = "e";
      5'd7:    ch = "s";
      5'd8:    ch = "-";
      5'd9:    ch = "w";
      5'd10:   ch = "a";
      5'd11:   ch = "i";
      5'd12:   ch = "t";
      5'd13:   ch = "i";
      5'd14:   ch = "n";
      5'd15:   ch = "g";
      5'd16:   ch = ":";
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // "voice-message:" by position
  function automatic logic [7:0] kw_voice(input logic [POS_W-1:0] p);
    logic [7:0] ch;
    case (p)
      5'd0:    ch = "v";
      5'd1:    ch = "o";
      5'd2:    ch = "i";
      5'd3:    ch = "c";
      5'd4:    ch = "e";
      5'd5:    ch = "-";
      5'd6:    ch = "m";
      5'd7:    ch = "e";
      5'd8:    ch = "s";
      5'd9:    ch = "s";
      5'd10:   ch = "a";
      5'd11:   ch = "g";
      5'd12:   ch = "e";
      5'd13:   ch = ":";
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // "yes" by position
  function automatic logic [7:0] kw_yes(input logic [POS_W-1:0] p);
    logic [7:0] ch;
    case (p)
      5'd0:    ch = "y";
      5'd1:    ch = "e";
      5'd2:    ch = "s";
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

### sv/mwi_message_summary_parser_unit.sv
// the last word is registered in the input stage, then its summary in the result register behind out_tvalid
// throughput: one word per cycle; a last word stalls while an unread result meets out_tready low
// the parser state is updated once per word by a single pass of compare and select logic
// reset (rst_n low, synchronous) empties both stages and puts the parser at line start
// with the waiting flag and all counts at zero; the same clear follows each last word
`timescale 1ns / 1ps
`include "mwi_message_summary_parser_unit_defines.svh"

module mwi_message_summary_parser_unit #(
  parameter int COUNT_BITS = mwi_msp_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [mwi_msp_pkg::IN_DATA_W-1:0]    in_tdata,   // [7:0] text_byte
  input  logic                                 in_tlast,   // last_byte
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [0] wait_flag, [16:1] nv_count, [32:17] ov_count,
  // [48:33] nu_count, [64:49] ou_count, [71:65] zero
  output logic [mwi_msp_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int               ACC_W   = COUNT_BITS + 4;
  localparam int               POS_W   = mwi_msp_pkg::POS_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // input stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // parser state
  mwi_msp_pkg::phase_t    phase_r, phase_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [COUNT_BITS-1:0]  acc_r, acc_nxt;
  logic                   wait_r, wait_nxt;
  logic [COUNT_BITS-1:0]  cnt_r   [4];
  logic [COUNT_BITS-1:0]  cnt_nxt [4];

  // result stage
  logic                                out_valid_r;
  logic [mwi_msp_pkg::OUT_DATA_W-1:0]  out_data_r, out_data_nxt;

  logic       out_free;
  logic       proc;
  logic [7:0] c;
  logic [7:0] lc;
  logic       do_yes, do_nsc, do_after, do_add, do_start, do_giveup;
  logic [1:0] start_k;
  logic [1:0] k;
  logic [POS_W-1:0] ypos;
  logic [31:0] w0, w1, w2, w3;

  // decimal step with saturation: acc * 10 + digit
  function automatic logic [COUNT_BITS-1:0] add_digit_f(
    input logic [COUNT_BITS-1:0] a,
    input logic [3:0]            d
  );
    logic [ACC_W-1:0] ext;
    logic [ACC_W-1:0] sum;
    ext = ACC_W'(a);
    sum = (ext << 3) + (ext << 1) + ACC_W'(d);
    return (sum > ACC_W'(CNT_MAX)) ? CNT_MAX : sum[COUNT_BITS-1:0];
  endfunction

  // handshake: a last word needs the result register free
  assign out_free  = !out_valid_r || out_tready;
  assign proc      = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || proc;

  assign c  = s1_byte_r;
  assign lc = mwi_msp_pkg::to_lower(s1_byte_r);

  // per-word parser update
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    wait_nxt  = wait_r;
    cnt_nxt   = cnt_r;
    do_yes    = 1'b0;
    do_nsc    = 1'b0;
    do_after  = 1'b0;
    do_add    = 1'b0;
    do_start  = 1'b0;
    do_giveup = 1'b0;
    start_k   = mwi_msp_pkg::CNT_NEW_VOICE;
    k         = pos_r[1:0];
    ypos      = pos_r;

    if (proc && phase_r != mwi_msp_pkg::PH_DONE) begin
      if (c == mwi_msp_pkg::CH_NUL) begin
        phase_nxt = mwi_msp_pkg::PH_DONE;
      end else begin
        case (phase_r)
          mwi_msp_pkg::PH_LINE: begin
            if (lc == mwi_msp_pkg::CH_LO_M) begin
              phase_nxt = mwi_msp_pkg::PH_KMW;
              pos_nxt   = POS_W'(1);
            end else if (lc == mwi_msp_pkg::CH_LO_V) begin
              phase_nxt = mwi_msp_pkg::PH_KVM;
              pos_nxt   = POS_W'(1);
            end else begin
              do_giveup = 1'b1;
            end
          end
          mwi_msp_pkg::PH_KMW: begin
            if (pos_r < POS_W'(mwi_msp_pkg::MW_LEN) &&
                lc == mwi_msp_pkg::kw_waiting(pos_r)) begin
              pos_nxt = pos_r + POS_W'(1);
              if (pos_r == POS_W'(mwi_msp_pkg::MW_LEN - 1)) begin
                phase_nxt = mwi_msp_pkg::PH_MWSP;
                pos_nxt   = '0;
                wait_nxt  = 1'b0;
              end
            end else begin
              do_giveup = 1'b1;
            end
          end
          mwi_msp_pkg::PH_KVM: begin
            if (pos_r < POS_W'(mwi_msp_pkg::VM_LEN) &&
                lc == mwi_msp_pkg::kw_voice(pos_r)) begin
              pos_nxt = pos_r + POS_W'(1);
              if (pos_r == POS_W'(mwi_msp_pkg::VM_LEN - 1)) begin
                phase_nxt = mwi_msp_pkg::PH_VMSP;
                pos_nxt   = '0;
              end
            end else begin
              do_giveup = 1'b1;
            end
          end
          mwi_msp_pkg::PH_MWSP: begin
            if (c != mwi_msp_pkg::CH_SPACE) begin
              ypos   = '0;
              do_yes = 1'b1;
            end
          end
          mwi_msp_pkg::PH_YES: begin
            do_yes = 1'b1;
          end
          mwi_msp_pkg::PH_SKIP: begin
            if (c == mwi_msp_pkg::CH_LF) begin
              phase_nxt = mwi_msp_pkg::PH_LINE;
            end
          end
          mwi_msp_pkg::PH_VMSP: begin
            if (c != mwi_msp_pkg::CH_SPACE) begin
              pos_nxt   = '0;
              acc_nxt   = '0;
              cnt_nxt[mwi_msp_pkg::CNT_NEW_VOICE] = '0;
              phase_nxt = mwi_msp_pkg::PH_NSTART;
              do_nsc    = 1'b1;
            end
          end
          mwi_msp_pkg::PH_NSTART: begin
            do_nsc = 1'b1;
          end
          mwi_msp_pkg::PH_NWS1: begin
            if (mwi_msp_pkg::is_digit(c)) begin
              do_add = 1'b1;
            end else if (mwi_msp_pkg::is_blank(c)) begin
              phase_nxt = mwi_msp_pkg::PH_NWS;
            end else if (pos_r == POS_W'(1) && c == mwi_msp_pkg::CH_LPAREN) begin
              do_start = 1'b1;
              start_k  = mwi_msp_pkg::CNT_NEW_URGENT;
            end else begin
              do_giveup = 1'b1;
            end
          end
          mwi_msp_pkg::PH_NWS: begin
            if (mwi_msp_pkg::is_digit(c)) begin
              do_add = 1'b1;
            end else if (!mwi_msp_pkg::is_blank(c)) begin
              do_giveup = 1'b1;
            end
          end
          mwi_msp_pkg::PH_NDIG: begin
            if (mwi_msp_pkg::is_digit(c)) begin
              do_add = 1'b1;
            end else begin
              do_after = 1'b1;
            end
          end
          mwi_msp_pkg::PH_PAREN: begin
            if (c == mwi_msp_pkg::CH_LPAREN) begin
              do_start = 1'b1;
              start_k  = mwi_msp_pkg::CNT_NEW_URGENT;
            end else begin
              do_giveup = 1'b1;
            end
          end
          default: begin
          end
        endcase

        // "yes" test after the waiting keyword
        if (do_yes) begin
          phase_nxt = mwi_msp_pkg::PH_YES;
          if (ypos < POS_W'(mwi_msp_pkg::YES_LEN) &&
              lc == mwi_msp_pkg::kw_yes(ypos)) begin
            pos_nxt = ypos + POS_W'(1);
            if (ypos == POS_W'(mwi_msp_pkg::YES_LEN - 1)) begin
              wait_nxt  = 1'b1;
              phase_nxt = mwi_msp_pkg::PH_SKIP;
              pos_nxt   = '0;
            end
          end else begin
            do_giveup = 1'b1;
          end
        end

        // first character of a count
        if (do_nsc) begin
          if (mwi_msp_pkg::is_digit(c)) begin
            do_add = 1'b1;
          end else if (mwi_msp_pkg::is_blank(c)) begin
            phase_nxt = (c == mwi_msp_pkg::CH_SPACE) ? mwi_msp_pkg::PH_NWS1
                                                     : mwi_msp_pkg::PH_NWS;
          end else begin
            do_after = 1'b1;
          end
        end

        // delimiter after a count
        k = pos_nxt[1:0];
        if (do_after) begin
          if ((k == mwi_msp_pkg::CNT_NEW_VOICE || k == mwi_msp_pkg::CNT_NEW_URGENT) &&
              c == mwi_msp_pkg::CH_SLASH) begin
            do_start = 1'b1;
            start_k  = k + 2'd1;
          end else if ((k == mwi_msp_pkg::CNT_NEW_VOICE ||
                        k == mwi_msp_pkg::CNT_OLD_VOICE) &&
                       c == mwi_msp_pkg::CH_SPACE) begin
            phase_nxt = mwi_msp_pkg::PH_PAREN;
          end else begin
            do_giveup = 1'b1;
          end
        end

        // begin a new count
        if (do_start) begin
          pos_nxt          = POS_W'(start_k);
          acc_nxt          = '0;
          cnt_nxt[start_k] = '0;
          phase_nxt        = mwi_msp_pkg::PH_NSTART;
        end

        // abandon the line
        if (do_giveup) begin
          phase_nxt = (c == mwi_msp_pkg::CH_LF) ? mwi_msp_pkg::PH_LINE
                                                : mwi_msp_pkg::PH_SKIP;
          pos_nxt   = '0;
        end

        // accumulate one decimal digit
        if (do_add) begin
          acc_nxt                = add_digit_f(acc_nxt, c[3:0]);
          cnt_nxt[pos_nxt[1:0]]  = acc_nxt;
          phase_nxt              = mwi_msp_pkg::PH_NDIG;
        end
      end
    end

    // result capture and clear on the last word
    w0 = 32'(cnt_nxt[mwi_msp_pkg::CNT_NEW_VOICE]);
    w1 = 32'(cnt_nxt[mwi_msp_pkg::CNT_OLD_VOICE]);
    w2 = 32'(cnt_nxt[mwi_msp_pkg::CNT_NEW_URGENT]);
    w3 = 32'(cnt_nxt[mwi_msp_pkg::CNT_OLD_URGENT]);
    out_data_nxt = {7'd0, w3[15:0], w2[15:0], w1[15:0], w0[15:0], wait_nxt};

    if (proc && s1_last_r) begin
      phase_nxt = mwi_msp_pkg::PH_LINE;
      pos_nxt   = '0;
      acc_nxt   = '0;
      wait_nxt  = 1'b0;
      for (int i = 0; i < 4; i++) begin
        cnt_nxt[i] = '0;
      end
    end
  end

  // input stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mwi_msp_pkg::PH_LINE;
      pos_r   <= '0;
      acc_r   <= '0;
      wait_r  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
      wait_r  <= wait_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (proc && s1_last_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `MWI_ASSERT_NEXT(a_clear_after_last, proc && s1_last_r,
    phase_r == mwi_msp_pkg::PH_LINE && pos_r == '0 && !wait_r && acc_r == '0,
    "parser state not cleared after last word")
  `MWI_ASSERT_IMPLY(a_stall_on_full, s1_valid_r && s1_last_r && out_valid_r && !out_tready,
    !in_tready && !proc, "last word processed while result still unread")
  `MWI_ASSERT_NEXT(a_result_on_last, proc && s1_last_r,
    out_tvalid, "no result after last word")
  `MWI_ASSERT_IMPLY(a_yes_pos, phase_r == mwi_msp_pkg::PH_YES,
    pos_r < POS_W'(mwi_msp_pkg::YES_LEN), "yes position out of range")

endmodule

### bench/mwi_message_summary_parser_unit_tb.sv
// self-checking testbench for the message summary parser: random bodies against a summary predictor
`timescale 1ns / 1ps

module mwi_message_summary_parser_unit_tb;
  import mwi_msp_pkg::*;

  localparam int unsigned COUNT_MAX   = (1 << COUNT_BITS_DEF) - 1;
  localparam int          WORD_TARGET = 1400;
  localparam int          BODY_MIN    = 20;
  localparam int          PAUSE_BODY  = 10;
  localparam int          QUIET_LIMIT = 1000;
  localparam int          DRAIN_WAIT  = 10;
  localparam int          SHOW_MAX    = 10;

  // predicts the summary of each body and checks what the block returns
  class summary_board;
    phase_t                phase;
    int                    pos;
    int unsigned           acc;
    logic                  waiting;
    logic [OUT_CNT_W-1:0]  counts [4];
    logic [OUT_DATA_W-1:0] summaries [$];
    int                    mismatches;
    string                 waiting_kw = "messages-waiting:";
    string                 voice_kw   = "voice-message:";
    string                 yes_kw     = "yes";

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      phase   = PH_LINE;
      pos     = 0;
      acc     = 0;
      waiting = 1'b0;
      foreach (counts[k]) counts[k] = '0;
    endfunction

    function int pending();
      return summaries.size();
    endfunction

    function logic [7:0] fold_case(logic [7:0] c);
      return (c >= CH_UP_A && c <= CH_UP_Z) ? (c | 8'h20) : c;
    endfunction

    function bit dec_char(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function bit blank_char(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
    endfunction

    // line feed restarts matching, anything else skips the rest of the line
    function void line_broken(logic [7:0] c);
      phase = (c == CH_LF) ? PH_LINE : PH_SKIP;
      pos   = 0;
    endfunction

    function void open_count(int k);
      pos       = k;
      acc       = 0;
      counts[k] = '0;
      phase     = PH_NSTART;
    endfunction

    // decimal accumulate with saturation
    function void push_digit(logic [7:0] c);
      int unsigned v;
      v = acc * RADIX + (c - CH_ZERO);
      if (v > COUNT_MAX) v = COUNT_MAX;
      acc         = v;
      counts[pos] = acc[OUT_CNT_W-1:0];
      phase       = PH_NDIG;
    endfunction

    // delimiter after a count decides which count comes next
    function void count_delim(logic [7:0] c);
      int k;
      k = pos;
      if ((k == CNT_NEW_VOICE || k == CNT_NEW_URGENT) && c == CH_SLASH) open_count(k + 1);
      else if (k <= CNT_OLD_VOICE && c == CH_SPACE) phase = PH_PAREN;
      else line_broken(c);
    endfunction

    function void count_first(logic [7:0] c);
      if (dec_char(c)) push_digit(c);
      else if (blank_char(c)) phase = (c == CH_SPACE) ? PH_NWS1 : PH_NWS;
      else count_delim(c);
    endfunction

    function void yes_step(logic [7:0] c);
      if (pos < yes_kw.len() && fold_case(c) == yes_kw[pos]) begin
        pos++;
        if (pos == yes_kw.len()) begin
          waiting = 1'b1;
          phase   = PH_SKIP;
          pos     = 0;
        end
      end else begin
        line_broken(c);
      end
    endfunction

    function void keyword_step(logic [7:0] c, string kw, phase_t nxt);
      if (pos < kw.len() && fold_case(c) == kw[pos]) begin
        pos++;
        if (pos == kw.len()) begin
          phase = nxt;
          pos   = 0;
          if (nxt == PH_MWSP) waiting = 1'b0;
        end
      end else begin
        line_broken(c);
      end
    endfunction

    function void take_char(logic [7:0] c);
      case (phase)
        PH_LINE: begin
          if (fold_case(c) == CH_LO_M) begin
            phase = PH_KMW;
            pos   = 1;
          end else if (fold_case(c) == CH_LO_V) begin
            phase = PH_KVM;
            pos   = 1;
          end else begin
            line_broken(c);
          end
        end
        PH_KMW: keyword_step(c, waiting_kw, PH_MWSP);
        PH_KVM: keyword_step(c, voice_kw, PH_VMSP);
        PH_MWSP: begin
          if (c != CH_SPACE) begin
            phase = PH_YES;
            pos   = 0;
            yes_step(c);
          end
        end
        PH_YES: yes_step(c);
        PH_SKIP: if (c == CH_LF) phase = PH_LINE;
        PH_VMSP: begin
          if (c != CH_SPACE) begin
            open_count(CNT_NEW_VOICE);
            count_first(c);
          end
        end
        PH_NSTART: count_first(c);
        PH_NWS1: begin
          if (dec_char(c)) push_digit(c);
          else if (blank_char(c)) phase = PH_NWS;
          else if (pos == CNT_OLD_VOICE && c == CH_LPAREN) open_count(CNT_NEW_URGENT);
          else line_broken(c);
        end
        PH_NWS: begin
          if (dec_char(c)) push_digit(c);
          else if (!blank_char(c)) line_broken(c);
        end
        PH_NDIG: begin
          if (dec_char(c)) push_digit(c);
          else count_delim(c);
        end
        PH_PAREN: begin
          if (c == CH_LPAREN) open_count(CNT_NEW_URGENT);
          else line_broken(c);
        end
        default: ;
      endcase
    endfunction

    // one accepted input word; a last word closes the body
    function void note_word(logic [7:0] c, logic last);
      logic [OUT_DATA_W-1:0] s;
      if (phase != PH_DONE) begin
        if (c == CH_NUL) phase = PH_DONE;
        else take_char(c);
      end
      if (last) begin
        s    = '0;
        s[0] = waiting;
        for (int k = 0; k < 4; k++) s[1 + k * OUT_CNT_W +: OUT_CNT_W] = counts[k];
        summaries.push_back(s);
        clear();
      end
    endfunction

    // one accepted result word against the oldest expected summary
    function void check_summary(logic [OUT_DATA_W-1:0] got);
      logic [OUT_DATA_W-1:0] want;
      bit                    bad;
      if (summaries.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX) $display("unexpected summary word %h", got);
        return;
      end
      want = summaries.pop_front();
      bad  = (got[0] !== want[0]);
      for (int k = 0; k < 4; k++)
        if (got[1 + k * OUT_CNT_W +: OUT_CNT_W] !== want[1 + k * OUT_CNT_W +: OUT_CNT_W]) bad = 1;
      if (got[OUT_DATA_W-1:4 * OUT_CNT_W + 1] !== want[OUT_DATA_W-1:4 * OUT_CNT_W + 1]) bad = 1;
      if (bad) begin
        mismatches++;
        if (mismatches <= SHOW_MAX) begin
          $display("summary mismatch exp/got: wait %0d/%0d nv %0d/%0d ov %0d/%0d",
                   want[0], got[0], want[16:1], got[16:1], want[32:17], got[32:17]);
          $display("  nu %0d/%0d ou %0d/%0d pad %h/%h",
                   want[48:33], got[48:33], want[64:49], got[64:49],
                   want[71:65], got[71:65]);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  summary_board board;
  logic [7:0]   body_q [$];
  bit           no_idle     = 1'b0;
  int           words_sent  = 0;
  int           bodies      = 0;
  int           quiet_count = 0;
  int           ready_hold  = 0;

  mwi_message_summary_parser_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 4))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_VT;
      3:       return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // text with random case flips and the odd high-bit corruption
  function automatic void add_text(string s, bit vary_case, bit may_corrupt);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (vary_case && (c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(0, 2) == 0)
        c = c ^ 8'h20;
      if (may_corrupt && $urandom_range(0, 59) == 0) c = c | 8'h80;
      body_q.push_back(c);
    end
  endfunction

  function automatic void add_spaces(int n);
    repeat (n) body_q.push_back(CH_SPACE);
  endfunction

  // optional leading blanks, 0..7 digits, rarely a sign
  function automatic void add_count();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 15) repeat ($urandom_range(1, 2)) body_q.push_back(pick_blank());
    r = $urandom_range(0, 99);
    if (r < 8) n = 0;
    else if (r < 70) n = $urandom_range(1, 2);
    else if (r < 88) n = $urandom_range(3, 4);
    else n = $urandom_range(5, 7);
    repeat (n) body_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 19) == 0) body_q.push_back($urandom_range(0, 1) ? "+" : "-");
  endfunction

  function automatic void add_voice_line();
    int r;
    bit paren;
    add_text("Voice-Message:", 1, 1);
    add_spaces($urandom_range(0, 2));
    add_count();
    if ($urandom_range(0, 99) < 80) begin
      body_q.push_back(CH_SLASH);
      add_count();
      r     = $urandom_range(0, 99);
      paren = 1'b1;
      if (r < 60) begin
        body_q.push_back(CH_SPACE);
      end else if (r < 75) begin
        body_q.push_back(pick_blank());
      end else if (r < 85) begin
        body_q.push_back(CH_SPACE);
        body_q.push_back(pick_blank());
      end else begin
        paren = 1'b0;
      end
      if (paren) begin
        body_q.push_back(CH_LPAREN);
        add_count();
        if ($urandom_range(0, 99) < 80) begin
          body_q.push_back(CH_SLASH);
          add_count();
        end
        body_q.push_back(")");
      end
    end
  endfunction

  function automatic void add_waiting_line();
    add_text("Messages-Waiting:", 1, 1);
    add_spaces($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0:       add_text("yes", 1, 1);
      1:       add_text("no", 1, 0);
      2:       add_text("ye", 0, 0);
      3:       add_text("yes", 0, 0);
      4:       add_text("Yesterday", 1, 0);
      default: body_q.push_back(8'($urandom_range(1, 255)));
    endcase
  endfunction

  // keyword cut short, followed by any byte
  function automatic void add_broken_line();
    string kw;
    if ($urandom_range(0, 1) != 0) kw = "Messages-Waiting:";
    else kw = "Voice-Message:";
    add_text(kw.substr(0, $urandom_range(0, kw.len() - 2)), 1, 0);
    body_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_noise_line();
    repeat ($urandom_range(1, 10))
      body_q.push_back(($urandom_range(0, 32) == 0) ? CH_NUL : 8'($urandom_range(1, 255)));
  endfunction

  // one body of one to three lines, sometimes cut anywhere
  function automatic void build_body();
    int nlines;
    int r;
    body_q.delete();
    nlines = $urandom_range(1, 3);
    for (int i = 0; i < nlines; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) add_voice_line();
      else if (r < 68) add_waiting_line();
      else if (r < 80) add_broken_line();
      else if (r < 95) add_noise_line();
      else begin
        body_q.push_back(CH_NUL);
        add_noise_line();
      end
      if (i < nlines - 1 || $urandom_range(0, 1)) body_q.push_back(CH_LF);
    end
    if ($urandom_range(0, 9) == 0 && body_q.size() > 1)
      repeat ($urandom_range(1, body_q.size() - 1)) void'(body_q.pop_back());
  endfunction

  // drive the body word by word, last word flagged
  task automatic send_body();
    int  g;
    logic lst;
    for (int i = 0; i < body_q.size(); i++) begin
      g   = pick_gap();
      lst = (i == body_q.size() - 1);
      if (g > 0) begin
        in_tvalid <= 1'b0;
        repeat (g) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= body_q[i];
      in_tlast  <= lst;
      do @(posedge clk); while (!in_tready);
      board.note_word(body_q[i], lst);
      words_sent++;
    end
  endtask

  // result side: check, random backpressure, watchdog
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_summary(out_tdata);
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_count = 0;
    else quiet_count++;
    if (quiet_count >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else if (ready_hold > 0) begin
      ready_hold--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      ready_hold = pick_gap();
    end
  end

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: top-bit bytes, text stopped by a zero byte, count saturation
    body_q = '{8'h80, 8'h7f};
    send_body();
    body_q = '{CH_NUL, 8'hff};
    send_body();
    body_q.delete();
    add_text("VOICE-MESSAGE:99999", 0, 0);
    send_body();

    // random bodies, idle and calm stretches alternate
    while (words_sent < WORD_TARGET || bodies < BODY_MIN) begin
      if (bodies % 40 == 39) no_idle = !no_idle;
      if (bodies == PAUSE_BODY || $urandom_range(0, 49) == 0) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
      end
      build_body();
      send_body();
      bodies++;
    end
    in_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
